// ----- hw/rtl/dad_pkg.sv -----
// Shared types, constants and calendar functions for the date add days unit.
`timescale 1ns / 1ps

package dad_pkg;

   // Field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int IN_YEAR_W = 12;
   localparam int YEAR_W   = 11;
   localparam int OFFSET_W = 17;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   // Day number across the supported span, wide enough for the offset reach
   localparam int SERIAL_W = 18;

   // Calendar limits
   localparam int YEAR_MIN   = 1902;
   localparam int YEAR_MAX   = 2037;
   localparam int MONTHS     = 12;
   localparam int LEAP_EVERY = 4;
   localparam int TOTAL_DAYS = (YEAR_MAX - YEAR_MIN + 1) * 365
                             + (YEAR_MAX - YEAR_MIN + 1) / LEAP_EVERY;

   // Reset values of the default date registers
   localparam logic [DAY_W-1:0]   DEFAULT_DAY_RST   = 5'd1;
   localparam logic [MONTH_W-1:0] DEFAULT_MONTH_RST = 4'd1;
   localparam logic [YEAR_W-1:0]  DEFAULT_YEAR_RST  = 11'd2000;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_DAY   = 2'd0,
      CSR_DEFAULT_MONTH = 2'd1,
      CSR_DEFAULT_YEAR  = 2'd2
   } csr_index_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_MONTH = 3'd1,
      ST_NOT_LEAP  = 3'd2,
      ST_BAD_DAY   = 3'd3,
      ST_BAD_YEAR  = 3'd4,
      ST_ABOVE_MAX = 3'd5,
      ST_BELOW_MIN = 3'd6
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SERIAL_YEAR,
      S_SERIAL_MONTH,
      S_ADJUST,
      S_RANGE,
      S_SPLIT_YEAR,
      S_SPLIT_MONTH,
      S_WRITE
   } state_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SERIAL_YEAR,
      OP_SERIAL_MONTH,
      OP_ADJUST,
      OP_RANGE,
      OP_SPLIT_YEAR,
      OP_SPLIT_MONTH,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic serial_year_more;
      logic serial_month_more;
      logic range_bad;
      logic split_year_more;
      logic split_month_more;
      logic rsp_free;
   } flags_type;

   // Length of a month with February taken as 29 days
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:    len = 5'd29;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Length of a month in a year of the given leap kind
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
      logic [DAY_W-1:0] len;
      if (m == 4'd2) begin
         len = leap ? 5'd29 : 5'd28;
      end else begin
         len = month_len(m);
      end
      return len;
   endfunction

   // Length of a year of the given leap kind
   function automatic logic [8:0] days_of_year(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

endpackage

// ----- hw/rtl/dad_if.sv -----
// Channel interfaces of the date add days unit: request, response and register write.
`timescale 1ns / 1ps

interface dad_req_if;
   import dad_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [DAY_W-1:0]           in_day;
   logic [MONTH_W-1:0]         in_month;
   logic [IN_YEAR_W-1:0]       in_year;
   logic signed [OFFSET_W-1:0] offset_days;

   modport source (output valid, in_day, in_month, in_year, offset_days, input ready);
   modport sink   (input valid, in_day, in_month, in_year, offset_days, output ready);
endinterface

interface dad_rsp_if;
   import dad_pkg::*;
   logic                valid;
   logic                ready;
   logic [DAY_W-1:0]    out_day;
   logic [MONTH_W-1:0]  out_month;
   logic [YEAR_W-1:0]   out_year;
   logic [STATUS_W-1:0] status;

   modport source (output valid, out_day, out_month, out_year, status, input ready);
   modport sink   (input valid, out_day, out_month, out_year, status, output ready);
endinterface

interface dad_csr_if;
   import dad_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/dad_datapath.sv -----
// Datapath of the date add days unit: default registers, validation, day walk, response register.
`timescale 1ns / 1ps

module dad_datapath (
   input  logic               clock,
   input  logic               reset,
   dad_req_if.sink            req_ch,
   dad_rsp_if.source          rsp_ch,
   dad_csr_if.sink            csr_ch,
   input  dad_pkg::cmd_type   cmd,
   output dad_pkg::flags_type flags
);
   import dad_pkg::*;

   // Default date registers
   logic [DAY_W-1:0]   def_day_ff;
   logic [MONTH_W-1:0] def_month_ff;
   logic [YEAR_W-1:0]  def_year_ff;

   // Working registers
   logic [DAY_W-1:0]          day_ff;
   logic [MONTH_W-1:0]        month_ff;
   logic [IN_YEAR_W-1:0]      year_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic signed [SERIAL_W-1:0] serial_ff;
   logic [YEAR_W-1:0]         walk_year_ff;
   logic [MONTH_W-1:0]        walk_month_ff;
   status_type                status_ff;

   // Response register
   logic                rsp_valid_ff;
   logic [DAY_W-1:0]    rsp_day_ff;
   logic [MONTH_W-1:0]  rsp_month_ff;
   logic [YEAR_W-1:0]   rsp_year_ff;
   status_type          rsp_status_ff;

   logic [DAY_W-1:0]      sub_day;
   logic [MONTH_W-1:0]    sub_month;
   logic [IN_YEAR_W-1:0]  sub_year;
   status_type            check_status;
   logic                  walk_leap;
   logic [DAY_W-1:0]      walk_month_days;
   logic [8:0]            walk_year_days;
   logic signed [SERIAL_W-1:0] adjusted;

   assign csr_ch.ready = 1'b1;

   // Register writes from the configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         def_day_ff   <= DEFAULT_DAY_RST;
         def_month_ff <= DEFAULT_MONTH_RST;
         def_year_ff  <= DEFAULT_YEAR_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_DEFAULT_DAY:   def_day_ff   <= csr_ch.wdata[DAY_W-1:0];
            CSR_DEFAULT_MONTH: def_month_ff <= csr_ch.wdata[MONTH_W-1:0];
            CSR_DEFAULT_YEAR:  def_year_ff  <= csr_ch.wdata[YEAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Substitution of zero fields by the defaults
   assign sub_day   = (req_ch.in_day == '0) ? def_day_ff : req_ch.in_day;
   assign sub_month = (req_ch.in_month == '0) ? def_month_ff : req_ch.in_month;
   assign sub_year  = (req_ch.in_year == '0) ? {1'b0, def_year_ff} : req_ch.in_year;

   // Validation of the substituted date, first failing check wins
   always_comb begin
      if (sub_month < 4'd1 || sub_month > 4'(MONTHS)) begin
         check_status = ST_BAD_MONTH;
      end else if (sub_month == 4'd2 && sub_day == 5'd29 && sub_year[1:0] != 2'd0) begin
         check_status = ST_NOT_LEAP;
      end else if (sub_day < 5'd1 || sub_day > month_len(sub_month)) begin
         check_status = ST_BAD_DAY;
      end else if (sub_year < 12'(YEAR_MIN) || sub_year > 12'(YEAR_MAX)) begin
         check_status = ST_BAD_YEAR;
      end else begin
         check_status = ST_OK;
      end
   end

   // Month and year lengths at the walk position
   assign walk_leap       = (walk_year_ff[1:0] == 2'd0);
   assign walk_year_days  = days_of_year(walk_leap);
   assign walk_month_days = days_in(walk_month_ff, (year_ff[1:0] == 2'd0));

   assign adjusted = serial_ff
                   + $signed({{(SERIAL_W-DAY_W){1'b0}}, day_ff})
                   - $signed(SERIAL_W'(1))
                   + $signed({{(SERIAL_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff});

   // Working registers follow the controller's operation
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            day_ff        <= sub_day;
            month_ff      <= sub_month;
            year_ff       <= sub_year;
            offset_ff     <= req_ch.offset_days;
            status_ff     <= check_status;
            serial_ff     <= '0;
            walk_year_ff  <= YEAR_W'(YEAR_MIN);
            walk_month_ff <= 4'd1;
         end
         OP_SERIAL_YEAR: begin
            serial_ff    <= serial_ff + $signed({{(SERIAL_W-9){1'b0}}, walk_year_days});
            walk_year_ff <= walk_year_ff + 1'b1;
         end
         OP_SERIAL_MONTH: begin
            serial_ff     <= serial_ff + $signed({{(SERIAL_W-DAY_W){1'b0}}, walk_month_days});
            walk_month_ff <= walk_month_ff + 1'b1;
         end
         OP_ADJUST: begin
            serial_ff     <= adjusted;
            walk_year_ff  <= YEAR_W'(YEAR_MIN);
            walk_month_ff <= 4'd1;
         end
         OP_RANGE: begin
            if (serial_ff[SERIAL_W-1]) begin
               status_ff <= ST_BELOW_MIN;
            end else if (serial_ff >= $signed(SERIAL_W'(TOTAL_DAYS))) begin
               status_ff <= ST_ABOVE_MAX;
            end
         end
         OP_SPLIT_YEAR: begin
            serial_ff    <= serial_ff - $signed({{(SERIAL_W-9){1'b0}}, walk_year_days});
            walk_year_ff <= walk_year_ff + 1'b1;
         end
         OP_SPLIT_MONTH: begin
            serial_ff     <= serial_ff - $signed({{(SERIAL_W-DAY_W){1'b0}},
                                                   days_in(walk_month_ff, walk_leap)});
            walk_month_ff <= walk_month_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Status toward the controller
   assign flags.invalid           = (status_ff != ST_OK);
   assign flags.serial_year_more  = ({1'b0, walk_year_ff} < year_ff);
   assign flags.serial_month_more = (walk_month_ff < month_ff);
   assign flags.range_bad         = serial_ff[SERIAL_W-1]
                                  || (serial_ff >= $signed(SERIAL_W'(TOTAL_DAYS)));
   assign flags.split_year_more   = (serial_ff >= $signed({{(SERIAL_W-9){1'b0}},
                                                            walk_year_days}));
   assign flags.split_month_more  = (serial_ff >= $signed({{(SERIAL_W-DAY_W){1'b0}},
                                                            days_in(walk_month_ff, walk_leap)}));
   assign flags.rsp_free          = !rsp_valid_ff || rsp_ch.ready;

   // Response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_WRITE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: the substituted date on error, else the walked date
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         rsp_status_ff <= status_ff;
         if (status_ff != ST_OK) begin
            rsp_day_ff   <= day_ff;
            rsp_month_ff <= month_ff;
            rsp_year_ff  <= year_ff[YEAR_W-1:0];
         end else begin
            rsp_day_ff   <= serial_ff[DAY_W-1:0] + 1'b1;
            rsp_month_ff <= walk_month_ff;
            rsp_year_ff  <= walk_year_ff;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_day   = rsp_day_ff;
   assign rsp_ch.out_month = rsp_month_ff;
   assign rsp_ch.out_year  = rsp_year_ff;
   assign rsp_ch.status    = rsp_status_ff;

endmodule

// ----- hw/rtl/dad_ctrl.sv -----
// Controller state machine of the date add days unit.
`timescale 1ns / 1ps

module dad_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dad_pkg::flags_type flags,
   output dad_pkg::cmd_type   cmd
);
   import dad_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and operation
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = flags.invalid ? S_WRITE : S_SERIAL_YEAR;
         end
         S_SERIAL_YEAR: begin
            if (flags.serial_year_more) begin
               cmd.op = OP_SERIAL_YEAR;
            end else begin
               state_in = S_SERIAL_MONTH;
            end
         end
         S_SERIAL_MONTH: begin
            if (flags.serial_month_more) begin
               cmd.op = OP_SERIAL_MONTH;
            end else begin
               state_in = S_ADJUST;
            end
         end
         S_ADJUST: begin
            cmd.op   = OP_ADJUST;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            cmd.op   = OP_RANGE;
            state_in = flags.range_bad ? S_WRITE : S_SPLIT_YEAR;
         end
         S_SPLIT_YEAR: begin
            if (flags.split_year_more) begin
               cmd.op = OP_SPLIT_YEAR;
            end else begin
               state_in = S_SPLIT_MONTH;
            end
         end
         S_SPLIT_MONTH: begin
            if (flags.split_month_more) begin
               cmd.op = OP_SPLIT_MONTH;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (flags.rsp_free) begin
               cmd.op   = OP_WRITE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/date_add_days_unit.sv -----
// Top level of the date add days unit: controller and datapath.
//
//   Channel   Direction  Carries
//   req_ch    in         in_day, in_month, in_year, offset_days
//   rsp_ch    out        out_day, out_month, out_year, status
//   csr_ch    in         index, wdata (default day, month, year)
//
// An invalid date skips the walk. Otherwise the datapath adds one year per
// cycle from 1902 to the input year, one month per cycle, then walks the
// resulting day number back through years and months. Reset is synchronous
// and restores the defaults 2000-01-01. A result waits in the response
// register while the next request is already accepted and worked.
`timescale 1ns / 1ps

module date_add_days_unit (
   input  logic      clock,
   input  logic      reset,
   dad_req_if.sink   req_ch,
   dad_rsp_if.source rsp_ch,
   dad_csr_if.sink   csr_ch
);
   import dad_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   dad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   dad_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .flags  (flags)
   );

endmodule
